/* hw/rtl/station_address_table_macros.svh */
// Assertion macros used by the station address table controller.
`ifndef STATION_ADDRESS_TABLE_MACROS_SVH
`define STATION_ADDRESS_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/sat_pkg.sv */
// Shared types, constants and helpers for the station address table.
`timescale 1ns / 1ps

package sat_pkg;

    // Table geometry
    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Request kinds; the unused code falls to the default arms
    typedef enum logic [2:0] {
        K_REGISTER    = 3'd0,
        K_UNREGISTER  = 3'd1,
        K_NET_BY_POS  = 3'd2,
        K_HW_BY_POS   = 3'd3,
        K_NET_BY_HW   = 3'd4,
        K_HW_BY_NET   = 3'd5,
        K_CLEAR       = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [47:0] hw_addr;
        logic [31:0] net_addr;
        logic [7:0]  position;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [2:0]  slot;
        logic [31:0] net_out;
        logic [47:0] hw_out;
        logic        dropped_full;
        logic [2:0]  latest_slot;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load;    // capture a new item, restart the scan
        logic step;    // examine one slot
        logic commit;  // update the table, load the result register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;  // slot under test is the last one
    } t_stat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    // Low three bits of a slot index
    function automatic logic [2:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W+2:0] wide;
        wide = {3'b000, idx};
        return wide[2:0];
    endfunction

endpackage

/* hw/rtl/sat_datapath.sv */
// Datapath: client table, sequential slot scan and result register.
`timescale 1ns / 1ps

module sat_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sat_pkg::t_in_item i_item,
    input  sat_pkg::t_cmd     i_cmd,
    output sat_pkg::t_stat    o_stat,
    output sat_pkg::t_out_item o_item
);
    import sat_pkg::*;

    // Table storage; contents of a slot only matter while its valid bit is set
    logic [ENTRIES-1:0] r_valid;
    logic [47:0]        r_hw  [ENTRIES];
    logic [31:0]        r_net [ENTRIES];
    logic [2:0]         r_latest;

    // Item and scan state
    t_in_item           r_cmd;
    logic [IDX_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_hit;
    logic [IDX_W-1:0]   r_hit_idx;
    logic               r_free;
    logic [IDX_W-1:0]   r_free_idx;
    t_out_item          r_out;

    logic               scan_match;
    logic [7:0]         cnt_ext;
    t_out_item          n_out;
    logic [2:0]         n_latest;
    logic               wr_net;
    logic               wr_new;
    logic               wr_unreg;
    logic               wr_clear;
    logic [47:0]        hit_hw;
    logic [31:0]        hit_net;

    assign cnt_ext = 8'(r_cnt);

    // Match test for the slot under scan
    always_comb begin
        scan_match = 1'b0;
        case (r_cmd.kind)
            K_REGISTER, K_UNREGISTER, K_NET_BY_HW: begin
                scan_match = r_valid[r_idx] && (r_hw[r_idx] == r_cmd.hw_addr);
            end
            K_HW_BY_NET: begin
                scan_match = r_valid[r_idx] && (r_net[r_idx] == r_cmd.net_addr);
            end
            K_NET_BY_POS, K_HW_BY_POS: begin
                scan_match = r_valid[r_idx] && (cnt_ext == r_cmd.position);
            end
            default: begin
                scan_match = 1'b0;
            end
        endcase
    end

    assign o_stat.scan_last = (r_idx == IDX_W'(ENTRIES - 1));

    // Scan: one slot per cycle, first hit and first free slot win
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_cmd.load) begin
            r_cmd      <= i_item;
            r_idx      <= '0;
            r_cnt      <= '0;
            r_hit      <= 1'b0;
            r_hit_idx  <= '0;
            r_free     <= 1'b0;
            r_free_idx <= '0;
        end else if (i_cmd.step) begin
            if (!r_hit && scan_match) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_idx;
            end
            if (!r_free && !r_valid[r_idx]) begin
                r_free     <= 1'b1;
                r_free_idx <= r_idx;
            end
            if (r_valid[r_idx]) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    assign hit_hw  = r_hw[r_hit_idx];
    assign hit_net = r_net[r_hit_idx];

    // Result and table update for the finished scan
    always_comb begin
        n_out    = '0;
        n_latest = r_latest;
        wr_net   = 1'b0;
        wr_new   = 1'b0;
        wr_unreg = 1'b0;
        wr_clear = 1'b0;
        case (r_cmd.kind)
            K_REGISTER: begin
                if (r_hit) begin
                    wr_net        = 1'b1;
                    n_latest      = slot_of(r_hit_idx);
                    n_out.found   = 1'b1;
                    n_out.slot    = slot_of(r_hit_idx);
                    n_out.net_out = r_cmd.net_addr;
                    n_out.hw_out  = hit_hw;
                end else if (r_free) begin
                    wr_new        = 1'b1;
                    n_out.found   = 1'b1;
                    n_out.slot    = slot_of(r_free_idx);
                    n_out.net_out = r_cmd.net_addr;
                    n_out.hw_out  = r_cmd.hw_addr;
                end else begin
                    n_out.dropped_full = 1'b1;
                end
            end
            K_UNREGISTER, K_NET_BY_POS, K_HW_BY_POS, K_NET_BY_HW, K_HW_BY_NET: begin
                if (r_hit) begin
                    wr_unreg      = (r_cmd.kind == K_UNREGISTER);
                    n_out.found   = 1'b1;
                    n_out.slot    = slot_of(r_hit_idx);
                    n_out.net_out = hit_net;
                    n_out.hw_out  = hit_hw;
                end
            end
            K_CLEAR: begin
                wr_clear = 1'b1;
                n_latest = '0;
            end
            default: begin
                n_out = '0;
            end
        endcase
        n_out.latest_slot = n_latest;
    end

    // Control part of the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_latest <= '0;
        end else if (i_cmd.commit) begin
            r_latest <= n_latest;
            if (wr_clear) begin
                r_valid <= '0;
            end else if (wr_new) begin
                r_valid[r_free_idx] <= 1'b1;
            end else if (wr_unreg) begin
                r_valid[r_hit_idx] <= 1'b0;
            end
        end
    end

    // Address storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (wr_new) begin
                r_hw[r_free_idx]  <= r_cmd.hw_addr;
                r_net[r_free_idx] <= r_cmd.net_addr;
            end else if (wr_net) begin
                r_net[r_hit_idx] <= r_cmd.net_addr;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_item = r_out;

endmodule

/* hw/rtl/sat_controller.sv */
// Controller: sequences accept, slot scan and commit, owns the output valid flag.
`timescale 1ns / 1ps
`include "station_address_table_macros.svh"

module sat_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  sat_pkg::t_stat i_stat,
    output sat_pkg::t_cmd  o_cmd
);
    import sat_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;
    logic   slot_free;

    // Result register can take a new item this cycle
    assign slot_free = !r_out_vld || i_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs and commands
    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
            end
            S_COMMIT: begin
                o_cmd.commit = slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Output valid flag
    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.commit) begin
            n_out_vld = 1'b1;
        end else if (i_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_valid = r_out_vld;

    `SAT_ASSERT_SAME(a_commit_slot_free, i_clk, i_rst_n, o_cmd.commit, !r_out_vld || i_ready)
    `SAT_ASSERT_NEXT(a_load_starts_scan, i_clk, i_rst_n, o_cmd.load, r_state == S_SCAN)
    `SAT_ASSERT_NEXT(a_last_to_commit, i_clk, i_rst_n,
                     (r_state == S_SCAN) && i_stat.scan_last, r_state == S_COMMIT)
    `SAT_ASSERT_SAME(a_valid_from_commit, i_clk, i_rst_n, $rose(r_out_vld), $past(o_cmd.commit))

endmodule

/* hw/rtl/station_address_table.sv */
// Top level of the station address table: controller plus datapath.
`timescale 1ns / 1ps

// Table of up to eight attached clients (valid bit, 48-bit hardware address,
// 32-bit network address). Each item registers, unregisters, looks up a client
// by ordinal, hardware address or network address, or clears the table, and
// yields exactly one result item. The scan walks the slots from slot 0 upward,
// one slot per cycle, and the first hit wins. Items are taken one at a time: the
// item is accepted and captured, every table slot is scanned, and then the table
// is written and the result register loaded before the next item is accepted.
// The result register decouples the output side: the next item is accepted
// while a result still waits, and that item holds in its commit cycle until
// the waiting result is taken. After reset the table is empty and ready for
// use at once.
module station_address_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sat_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output sat_pkg::t_out_item o_item
);
    import sat_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sat_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    sat_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_item  (o_item)
    );

endmodule

/* tb/station_address_table_checker.sv */
// Checker for the station address table: tracks the table and compares each result item.
`timescale 1ns / 1ps

module station_address_table_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  sat_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  sat_pkg::t_out_item i_out_item,
    output int                 o_mismatches,
    output int                 o_pending,
    output int                 o_checked
);
    import sat_pkg::*;

    // Shadow copy of the client table
    logic        shadow_valid [ENTRIES];
    logic [47:0] shadow_hw    [ENTRIES];
    logic [31:0] shadow_net   [ENTRIES];
    logic [2:0]  shadow_latest;

    t_out_item awaited_results [$];
    int        mismatch_cnt;
    int        checked_cnt;

    function automatic void wipe_table();
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_hw[i]    = '0;
            shadow_net[i]   = '0;
        end
        shadow_latest = '0;
    endfunction

    function automatic int slot_with_hw(logic [47:0] hw);
        for (int i = 0; i < ENTRIES; i++)
            if (shadow_valid[i] && shadow_hw[i] == hw) return i;
        return -1;
    endfunction

    function automatic int slot_with_net(logic [31:0] net);
        for (int i = 0; i < ENTRIES; i++)
            if (shadow_valid[i] && shadow_net[i] == net) return i;
        return -1;
    endfunction

    // Ordinal among valid entries, counted from slot 0
    function automatic int slot_at_position(logic [7:0] pos);
        int n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_valid[i]) begin
                if (n == int'(pos)) return i;
                n++;
            end
        end
        return -1;
    endfunction

    // Apply one request to the shadow table and return the result it yields
    function automatic t_out_item apply_request(t_in_item req);
        int        hit;
        logic      drop;
        t_out_item res;
        hit  = -1;
        drop = 1'b0;
        case (req.kind)
            K_REGISTER: begin
                hit = slot_with_hw(req.hw_addr);
                if (hit >= 0) begin
                    shadow_net[hit] = req.net_addr;
                    shadow_latest   = hit[2:0];
                end else begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!shadow_valid[i]) begin
                            shadow_valid[i] = 1'b1;
                            shadow_hw[i]    = req.hw_addr;
                            shadow_net[i]   = req.net_addr;
                            hit = i;
                            break;
                        end
                    end
                    if (hit < 0) drop = 1'b1;
                end
            end
            K_UNREGISTER: begin
                hit = slot_with_hw(req.hw_addr);
                // addresses stay in place, only the valid bit drops
                if (hit >= 0) shadow_valid[hit] = 1'b0;
            end
            K_NET_BY_POS, K_HW_BY_POS: hit = slot_at_position(req.position);
            K_NET_BY_HW:               hit = slot_with_hw(req.hw_addr);
            K_HW_BY_NET:               hit = slot_with_net(req.net_addr);
            K_CLEAR:                   wipe_table();
            default:                   hit = -1;
        endcase
        res = '0;
        if (hit >= 0) begin
            res.found   = 1'b1;
            res.slot    = hit[2:0];
            res.net_out = shadow_net[hit];
            res.hw_out  = shadow_hw[hit];
        end
        res.dropped_full = drop;
        res.latest_slot  = shadow_latest;
        return res;
    endfunction

    // Result side first: an item accepted on this edge cannot have its result yet
    always @(posedge i_clk) begin : monitor
        t_out_item exp_res;
        if (!i_rst_n) begin
            wipe_table();
            awaited_results.delete();
            mismatch_cnt = 0;
            checked_cnt  = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                checked_cnt++;
                if (awaited_results.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("[%0t] result item with none outstanding: found=%0b slot=%0d",
                                 $realtime, i_out_item.found, i_out_item.slot);
                    mismatch_cnt++;
                end else begin
                    exp_res = awaited_results.pop_front();
                    if (i_out_item.found        !== exp_res.found        ||
                        i_out_item.slot         !== exp_res.slot         ||
                        i_out_item.net_out      !== exp_res.net_out      ||
                        i_out_item.hw_out       !== exp_res.hw_out       ||
                        i_out_item.dropped_full !== exp_res.dropped_full ||
                        i_out_item.latest_slot  !== exp_res.latest_slot) begin
                        if (mismatch_cnt < 10) begin
                            $display({"[%0t] mismatch exp: found=%0b slot=%0d net=%h",
                                      " hw=%h drop=%0b latest=%0d"},
                                     $realtime, exp_res.found, exp_res.slot, exp_res.net_out,
                                     exp_res.hw_out, exp_res.dropped_full, exp_res.latest_slot);
                            $display({"              got: found=%0b slot=%0d net=%h",
                                      " hw=%h drop=%0b latest=%0d"},
                                     i_out_item.found, i_out_item.slot, i_out_item.net_out,
                                     i_out_item.hw_out, i_out_item.dropped_full,
                                     i_out_item.latest_slot);
                        end
                        mismatch_cnt++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                awaited_results.push_back(apply_request(i_in_item));
        end
        o_mismatches <= mismatch_cnt;
        o_pending    <= awaited_results.size();
        o_checked    <= checked_cnt;
    end

endmodule

/* tb/tb_station_address_table.sv */
// Testbench top for the station address table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_station_address_table;
    import sat_pkg::*;

    localparam int RANDOM_ITEMS   = 1400;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HW_POOL        = 12;
    localparam int NET_POOL       = 6;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_ready = 1'b0;
    t_in_item  i_item  = '0;
    logic      o_ready;
    logic      o_valid;
    t_out_item o_item;

    int mismatches;
    int pending;
    int checked;
    int hold_requests = 0;
    int kind_counts [8];

    // Client addresses reused so that lookups and re-registers hit
    logic [47:0] hw_pool  [HW_POOL];
    logic [31:0] net_pool [NET_POOL];

    station_address_table i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    station_address_table_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_item    (i_item),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_item   (o_item),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [47:0] rand_hw();
        logic [31:0] hi;
        logic [31:0] lo;
        hi = $urandom;
        lo = $urandom;
        return {hi[15:0], lo};
    endfunction

    function automatic t_in_item make_item(logic [2:0] kind, logic [47:0] hw,
                                           logic [31:0] net, logic [7:0] pos);
        t_in_item it;
        it.kind     = t_kind'(kind);
        it.hw_addr  = hw;
        it.net_addr = net;
        it.position = pos;
        return it;
    endfunction

    task automatic refresh_pools();
        for (int i = 0; i < HW_POOL; i++) hw_pool[i] = rand_hw();
        for (int i = 0; i < NET_POOL; i++) net_pool[i] = $urandom;
    endtask

    // Mostly pool-based requests; a small share is pure noise
    function automatic t_in_item random_request();
        t_in_item it;
        int       pick;
        logic [2:0] k;
        pick = $urandom_range(99);
        if (pick < 30)      k = K_REGISTER;
        else if (pick < 44) k = K_UNREGISTER;
        else if (pick < 54) k = K_NET_BY_POS;
        else if (pick < 64) k = K_HW_BY_POS;
        else if (pick < 76) k = K_NET_BY_HW;
        else if (pick < 88) k = K_HW_BY_NET;
        else if (pick < 90) k = K_CLEAR;
        else                k = 3'($urandom_range(7));
        it = make_item(k, hw_pool[$urandom_range(HW_POOL - 1)],
                       net_pool[$urandom_range(NET_POOL - 1)], 8'($urandom_range(9)));
        if ($urandom_range(9) == 0)  it.position = 8'($urandom);
        if ($urandom_range(19) == 0) it.hw_addr  = rand_hw();
        if ($urandom_range(19) == 0) it.net_addr = $urandom;
        return it;
    endfunction

    // Offer one item and hold it until accepted
    task automatic send_item(t_in_item it);
        i_valid <= 1'b1;
        i_item  <= it;
        kind_counts[int'(it.kind)]++;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every outstanding result is back
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Receiver: changing stall patterns, plus long holds on request
    initial begin : receiver
        int mode;
        int mode_left;
        int phase;
        int holds_served;
        mode         = 0;
        mode_left    = 0;
        phase        = 0;
        holds_served = 0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_served) begin
                holds_served++;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            phase++;
            case (mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= 1'($urandom_range(1));
                2:       i_ready <= ($urandom_range(3) == 0);
                default: i_ready <= (phase % 4 != 3);
            endcase
        end
    end

    // Watchdog on cycles with no handshake on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) quiet = 0;
            else quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        logic [47:0] fresh [7];
        logic [31:0] shared_net;
        int          sent;
        int          burst;
        bit          held;
        bit          paused;
        t_in_item    it;

        for (int i = 0; i < 8; i++) kind_counts[i] = 0;
        refresh_pools();
        for (int i = 0; i < 7; i++) fresh[i] = rand_hw();
        shared_net = $urandom;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, full table, duplicate network address, clear
        send_item(make_item(K_REGISTER, '0, '0, '0));
        send_item(make_item(K_REGISTER, '1, '1, '0));
        send_item(make_item(K_REGISTER, fresh[0], shared_net, '0));
        send_item(make_item(K_REGISTER, fresh[1], shared_net, '0));
        send_item(make_item(K_HW_BY_NET, '0, shared_net, '0));     // first hit wins
        send_item(make_item(K_NET_BY_POS, '0, '0, 8'd0));
        send_item(make_item(K_HW_BY_POS, '0, '0, 8'd3));
        send_item(make_item(K_NET_BY_POS, '1, '1, 8'd255));       // beyond valid count
        send_item(make_item(K_NET_BY_HW, '1, '0, '0));
        send_item(make_item(K_NET_BY_HW, fresh[6], '0, '0));      // no match
        send_item(make_item(K_HW_BY_NET, '0, '0, '0));
        send_item(make_item(K_REGISTER, '1, 32'h1234_5678, '0)); // known client
        for (int i = 2; i < 6; i++)
            send_item(make_item(K_REGISTER, fresh[i], 32'($urandom), '0));
        send_item(make_item(K_REGISTER, fresh[6], '1, '0));       // table full
        send_item(make_item(K_UNREGISTER, '0, '0, '0));
        send_item(make_item(K_UNREGISTER, '0, '0, '0));           // already gone
        send_item(make_item(K_HW_BY_POS, '0, '0, 8'd0));
        send_item(make_item(K_REGISTER, fresh[6], '1, '0));       // reuses lowest free slot
        send_item(make_item(3'd7, '1, '1, '1));                   // unused kind
        send_item(make_item(K_CLEAR, '1, '1, '1));
        send_item(make_item(K_NET_BY_POS, '0, '0, 8'd0));
        send_item(make_item(K_HW_BY_NET, '0, '0, '0));
        wait_drained();

        // Random bursts with gaps; one long receiver hold and one full drain
        sent   = 0;
        held   = 1'b0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
                it = random_request();
                send_item(it);
                sent++;
                if (it.kind == K_CLEAR && $urandom_range(1) == 1) refresh_pools();
            end
            if (!held && sent >= 400) begin
                held = 1'b1;
                hold_requests <= hold_requests + 1;
                for (int b = 0; b < 12; b++) begin
                    send_item(random_request());
                    sent++;
                end
            end else if (!paused && sent >= 800) begin
                paused = 1'b1;
                wait_drained();
            end else if ($urandom_range(3) != 0) begin
                idle_gap($urandom_range(1, 8));
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d items: %0d register, %0d unregister, %0d lookup, %0d clear, %0d unused",
                 sent + 25, kind_counts[K_REGISTER], kind_counts[K_UNREGISTER],
                 kind_counts[K_NET_BY_POS] + kind_counts[K_HW_BY_POS] +
                 kind_counts[K_NET_BY_HW] + kind_counts[K_HW_BY_NET],
                 kind_counts[K_CLEAR], kind_counts[7]);
        $display("Checked %0d result items, %0d mismatches", checked, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/sat_pkg.sv
hw/rtl/sat_datapath.sv
hw/rtl/sat_controller.sv
hw/rtl/station_address_table.sv
tb/station_address_table_checker.sv
tb/tb_station_address_table.sv
